>>> rtl/frame_time_capture_stats_top_assert.svh
// Assertion macros for the frame time capture monitor.
`ifndef FRAME_TIME_CAPTURE_STATS_TOP_ASSERT_SVH
`define FRAME_TIME_CAPTURE_STATS_TOP_ASSERT_SVH

// Check an implication that holds at every clock edge outside reset.
`define FTCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define FTCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/ftcs_pkg.sv
// Shared types and constants of the frame time capture monitor.
package ftcs_pkg;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned AddrW      = $clog2(MaxSamples);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned FrameW     = 24;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned SumW       = FrameW + AddrW;
  localparam int unsigned DivSteps   = SumW;
  localparam int unsigned DivCntW    = $clog2(DivSteps + 1);
  localparam int unsigned BitW       = $clog2(FrameW);
  // rank = ceil(0.95 n) - 1 = (19 n + 19) / 20 - 1, divide by 20 via reciprocal
  localparam int unsigned RankXW     = $clog2(19 * MaxSamples + 20);
  localparam int unsigned RankShift  = 24;
  localparam int unsigned RankRecip  = 838861;
  localparam int unsigned RankProdW  = RankShift + CntW;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WARM = 2'd1,
    PH_CAPT = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_RESET = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WARMUP  = 2'd0,
    REG_CAPTURE = 2'd1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RANK,
    S_SCAN,
    S_BIT,
    S_DIV,
    S_RESP
  } state_e;

  typedef struct packed {
    logic take;
    logic exec;
    logic rank;
    logic scan_init;
    logic scan;
    logic bit_step;
    logic div_init;
    logic div_step;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic finish;
    logic pass_done;
    logic bit_last;
    logic div_done;
  } dp_stat_t;

endpackage

>>> rtl/frame_time_capture_stats_top.sv
// Top level of the frame time capture monitor.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   cmd_i, frame_us_i
//   out      output     out_valid_o/out_ready_i phase_o .. dropped_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item at a time. An item that does not complete a capture passes from the execute
// state to the response state, which loads its result into the output register once the
// previous result is taken; the next item is accepted after that. The completing tick
// runs 24 passes over the n stored samples (one memory read a cycle) to find the 95th
// percentile, then runs the serial divider for the mean before its result is loaded.
// Reset clears all control and statistics state; the sample store needs no clearing.
// A result waits in the output register while the next item is accepted.
module frame_time_capture_stats_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [ftcs_pkg::FrameW-1:0]         frame_us_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          phase_o,
  output logic [ftcs_pkg::TimeW-1:0]          remaining_us_o,
  output logic [ftcs_pkg::CntW-1:0]           count_o,
  output logic [ftcs_pkg::TimeW-1:0]          captured_total_us_o,
  output logic [ftcs_pkg::FrameW-1:0]         mean_us_o,
  output logic [ftcs_pkg::FrameW-1:0]         p95_us_o,
  output logic [ftcs_pkg::FrameW-1:0]         max_us_o,
  output logic                                dropped_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [ftcs_pkg::TimeW-1:0]          cfg_data_i
);

  ftcs_pkg::ctrl_cmd_t ctrl_cmd;
  ftcs_pkg::dp_stat_t  dp_stat;
  logic                out_done;
  logic                count_ok;

  assign cfg_ready_o = 1'b1;

  ftcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  ftcs_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (ctrl_cmd),
    .stat_o              (dp_stat),
    .cfg_we_i            (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_cmd_i            (cmd_i),
    .in_frame_i          (frame_us_i),
    .phase_o             (phase_o),
    .remaining_us_o      (remaining_us_o),
    .count_o             (count_o),
    .captured_total_us_o (captured_total_us_o),
    .mean_us_o           (mean_us_o),
    .p95_us_o            (p95_us_o),
    .max_us_o            (max_us_o),
    .dropped_o           (dropped_o)
  );

  assign out_done = (phase_o == ftcs_pkg::PH_DONE);
  assign count_ok = (count_o <= ftcs_pkg::CntW'(ftcs_pkg::MaxSamples));

`include "frame_time_capture_stats_top_assert.svh"

  `FTCS_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "item overlap")
  `FTCS_ASSERT(a_count_done, (out_valid_o && count_o != '0) |-> out_done, "count outside done")
  `FTCS_ASSERT(a_count_max, out_valid_o |-> count_ok, "count above capacity")
  `FTCS_ASSERT(a_p95_le_max, (out_valid_o) |-> (p95_us_o <= max_us_o), "p95 above max")

endmodule

>>> rtl/ftcs_ctrl.sv
// Sequencer of the frame time capture monitor: handshakes and summary passes.
module ftcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ftcs_pkg::dp_stat_t   stat_i,
  output ftcs_pkg::ctrl_cmd_t  cmd_o
);

  ftcs_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ftcs_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ftcs_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ftcs_pkg::S_EXEC;
      end
      ftcs_pkg::S_EXEC: begin
        state_d = stat_i.finish ? ftcs_pkg::S_RANK : ftcs_pkg::S_RESP;
      end
      ftcs_pkg::S_RANK: state_d = ftcs_pkg::S_SCAN;
      ftcs_pkg::S_SCAN: begin
        if (stat_i.pass_done) state_d = ftcs_pkg::S_BIT;
      end
      ftcs_pkg::S_BIT: begin
        state_d = stat_i.bit_last ? ftcs_pkg::S_DIV : ftcs_pkg::S_SCAN;
      end
      ftcs_pkg::S_DIV: begin
        if (stat_i.div_done) state_d = ftcs_pkg::S_RESP;
      end
      ftcs_pkg::S_RESP: begin
        if (out_free) state_d = ftcs_pkg::S_IDLE;
      end
      default: state_d = ftcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ftcs_pkg::S_IDLE: cmd_o.take = in_valid_i;
      ftcs_pkg::S_EXEC: cmd_o.exec = 1'b1;
      ftcs_pkg::S_RANK: begin
        cmd_o.rank      = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      ftcs_pkg::S_SCAN: cmd_o.scan = 1'b1;
      ftcs_pkg::S_BIT: begin
        cmd_o.bit_step  = 1'b1;
        cmd_o.scan_init = !stat_i.bit_last;
        cmd_o.div_init  = stat_i.bit_last;
      end
      ftcs_pkg::S_DIV: begin
        cmd_o.div_step = !stat_i.div_done;
        cmd_o.commit   = stat_i.div_done;
      end
      ftcs_pkg::S_RESP: cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ftcs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/ftcs_dp.sv
// Datapath of the frame time capture monitor: budgets, sample store, selection, mean.
module ftcs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ftcs_pkg::ctrl_cmd_t           cmd_i,
  output ftcs_pkg::dp_stat_t            stat_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [ftcs_pkg::TimeW-1:0]    cfg_data_i,
  input  logic [1:0]                    in_cmd_i,
  input  logic [ftcs_pkg::FrameW-1:0]   in_frame_i,
  output logic [1:0]                    phase_o,
  output logic [ftcs_pkg::TimeW-1:0]    remaining_us_o,
  output logic [ftcs_pkg::CntW-1:0]     count_o,
  output logic [ftcs_pkg::TimeW-1:0]    captured_total_us_o,
  output logic [ftcs_pkg::FrameW-1:0]   mean_us_o,
  output logic [ftcs_pkg::FrameW-1:0]   p95_us_o,
  output logic [ftcs_pkg::FrameW-1:0]   max_us_o,
  output logic                          dropped_o
);

  localparam int unsigned FW = ftcs_pkg::FrameW;
  localparam int unsigned TW = ftcs_pkg::TimeW;
  localparam int unsigned CW = ftcs_pkg::CntW;
  localparam int unsigned AW = ftcs_pkg::AddrW;
  localparam int unsigned SW = ftcs_pkg::SumW;

  // configuration
  logic [TW-1:0] warmup_cfg_q, capture_cfg_q;

  // latched item
  logic [1:0]    cmd_q;
  logic [FW-1:0] frame_q;

  // architectural state
  ftcs_pkg::phase_e phase_q, phase_d;
  logic [TW-1:0] warm_left_q, warm_left_d;
  logic [TW-1:0] capt_left_q, capt_left_d;
  logic [TW-1:0] total_q, total_d;
  logic [CW-1:0] n_q, n_d;
  logic          drop_q, drop_d;
  logic [FW-1:0] mean_q, mean_d;
  logic [FW-1:0] p95_q, p95_d;
  logic [FW-1:0] max_q, max_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [FW-1:0] run_max_q, run_max_d;

  logic [FW-1:0] mem [ftcs_pkg::MaxSamples];
  logic          store;
  logic [TW:0]   total_add;
  logic          finish;

  // selection and division
  logic [CW-1:0]        rd_addr_q;
  logic                 rd_valid_q;
  logic [FW-1:0]        rdata_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        k_q;
  logic [FW-1:0]        prefix_q;
  logic [ftcs_pkg::BitW-1:0] bit_q;
  logic [ftcs_pkg::BitW:0]   bit_p1;
  logic [FW-1:0]        hi_mask;
  logic                 match;
  logic                 issue;
  logic [ftcs_pkg::RankXW-1:0]    rank_x;
  logic [ftcs_pkg::RankProdW-1:0] rank_prod;
  logic [CW-1:0]        rank;
  logic [SW-1:0]        quo_q;
  logic [CW-1:0]        rem_q;
  logic [CW:0]          rem_sh;
  logic                 rem_ge;
  logic [ftcs_pkg::DivCntW-1:0] div_cnt_q;

  // output register
  logic [1:0]    o_phase_q;
  logic [TW-1:0] o_rem_q, o_total_q;
  logic [CW-1:0] o_count_q;
  logic [FW-1:0] o_mean_q, o_p95_q, o_max_q;
  logic          o_drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_cfg_q  <= '0;
      capture_cfg_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ftcs_pkg::REG_WARMUP)  warmup_cfg_q  <= cfg_data_i;
      if (cfg_index_i == ftcs_pkg::REG_CAPTURE) capture_cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q   <= in_cmd_i;
      frame_q <= in_frame_i;
    end
  end

  assign total_add = {1'b0, total_q} + (TW+1)'(frame_q);

  always_comb begin
    phase_d     = phase_q;
    warm_left_d = warm_left_q;
    capt_left_d = capt_left_q;
    total_d     = total_q;
    n_d         = n_q;
    drop_d      = drop_q;
    mean_d      = mean_q;
    p95_d       = p95_q;
    max_d       = max_q;
    sum_d       = sum_q;
    run_max_d   = run_max_q;
    store       = 1'b0;
    finish      = 1'b0;
    if (cmd_i.exec) begin
      case (cmd_q)
        ftcs_pkg::CMD_TICK: begin
          if (frame_q != '0) begin
            if (phase_q == ftcs_pkg::PH_WARM) begin
              if ((TW)'(frame_q) >= warm_left_q) begin
                warm_left_d = '0;
                phase_d     = ftcs_pkg::PH_CAPT;
              end else begin
                warm_left_d = warm_left_q - (TW)'(frame_q);
              end
            end else if (phase_q == ftcs_pkg::PH_CAPT) begin
              if (n_q < CW'(ftcs_pkg::MaxSamples)) begin
                store     = 1'b1;
                n_d       = n_q + 1'b1;
                sum_d     = sum_q + SW'(frame_q);
                if (frame_q > run_max_q) run_max_d = frame_q;
              end else begin
                drop_d = 1'b1;
              end
              total_d = total_add[TW] ? {TW{1'b1}} : total_add[TW-1:0];
              if ((TW)'(frame_q) >= capt_left_q) begin
                capt_left_d = '0;
                phase_d     = ftcs_pkg::PH_DONE;
                finish      = 1'b1;
              end else begin
                capt_left_d = capt_left_q - (TW)'(frame_q);
              end
            end
          end
        end
        ftcs_pkg::CMD_START, ftcs_pkg::CMD_RESET: begin
          phase_d     = ftcs_pkg::PH_IDLE;
          warm_left_d = '0;
          capt_left_d = '0;
          total_d     = '0;
          n_d         = '0;
          drop_d      = 1'b0;
          mean_d      = '0;
          p95_d       = '0;
          max_d       = '0;
          sum_d       = '0;
          run_max_d   = '0;
          if (cmd_q == ftcs_pkg::CMD_START && capture_cfg_q != '0) begin
            warm_left_d = warmup_cfg_q;
            capt_left_d = capture_cfg_q;
            phase_d     = (warmup_cfg_q != '0) ? ftcs_pkg::PH_WARM : ftcs_pkg::PH_CAPT;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.commit) begin
      mean_d = quo_q[FW-1:0];
      p95_d  = prefix_q;
      max_d  = run_max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ftcs_pkg::PH_IDLE;
      warm_left_q <= '0;
      capt_left_q <= '0;
      total_q     <= '0;
      n_q         <= '0;
      drop_q      <= 1'b0;
      mean_q      <= '0;
      p95_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      run_max_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      warm_left_q <= warm_left_d;
      capt_left_q <= capt_left_d;
      total_q     <= total_d;
      n_q         <= n_d;
      drop_q      <= drop_d;
      mean_q      <= mean_d;
      p95_q       <= p95_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      run_max_q   <= run_max_d;
    end
  end

  // sample store: write on capture, one registered read per scan cycle until all n are read
  assign issue = cmd_i.scan && (rd_addr_q < n_q);

  always_ff @(posedge clk_i) begin
    if (store) mem[n_q[AW-1:0]] <= frame_q;
    if (issue) rdata_q <= mem[rd_addr_q[AW-1:0]];
  end

  assign rank_x    = ftcs_pkg::RankXW'(n_q) * ftcs_pkg::RankXW'(19)
                   + ftcs_pkg::RankXW'(19);
  assign rank_prod = ftcs_pkg::RankProdW'(rank_x)
                   * ftcs_pkg::RankProdW'(ftcs_pkg::RankRecip);
  assign rank      = rank_prod[ftcs_pkg::RankShift +: CW] - 1'b1;

  // radix select: fix one bit of the ranked sample per pass, MSB first
  assign bit_p1  = {1'b0, bit_q} + 1'b1;
  assign hi_mask = {FW{1'b1}} << bit_p1;
  assign match   = (((rdata_q ^ prefix_q) & hi_mask) == '0) && !rdata_q[bit_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q  <= '0;
      rd_valid_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      rd_addr_q  <= '0;
      rd_valid_q <= 1'b0;
    end else if (cmd_i.scan) begin
      rd_valid_q <= issue;
      if (issue) rd_addr_q <= rd_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rank) begin
      k_q      <= rank;
      prefix_q <= '0;
      bit_q    <= ftcs_pkg::BitW'(FW - 1);
    end
    if (cmd_i.scan_init) begin
      cnt_q <= '0;
    end else if (cmd_i.scan && rd_valid_q && match) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.bit_step) begin
      if (k_q >= cnt_q) begin
        k_q             <= k_q - cnt_q;
        prefix_q[bit_q] <= 1'b1;
      end
      bit_q <= bit_q - 1'b1;
    end
  end

  // restoring divider for the mean, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[SW-1]};
  assign rem_ge = rem_sh >= {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      div_cnt_q <= ftcs_pkg::DivCntW'(ftcs_pkg::DivSteps);
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SW-2:0], rem_ge};
      rem_q <= rem_ge ? CW'(rem_sh - {1'b0, n_q}) : rem_sh[CW-1:0];
    end
  end

  assign stat_o.finish    = finish;
  assign stat_o.pass_done = (rd_addr_q == n_q) && !rd_valid_q;
  assign stat_o.bit_last  = (bit_q == '0);
  assign stat_o.div_done  = (div_cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      o_phase_q <= phase_q;
      o_rem_q   <= (phase_q == ftcs_pkg::PH_WARM) ? warm_left_q :
                   (phase_q == ftcs_pkg::PH_CAPT) ? capt_left_q : '0;
      o_count_q <= (phase_q == ftcs_pkg::PH_DONE) ? n_q : '0;
      o_total_q <= (phase_q == ftcs_pkg::PH_DONE) ? total_q : '0;
      o_mean_q  <= mean_q;
      o_p95_q   <= p95_q;
      o_max_q   <= max_q;
      o_drop_q  <= drop_q;
    end
  end

  assign phase_o             = o_phase_q;
  assign remaining_us_o      = o_rem_q;
  assign count_o             = o_count_q;
  assign captured_total_us_o = o_total_q;
  assign mean_us_o           = o_mean_q;
  assign p95_us_o            = o_p95_q;
  assign max_us_o            = o_max_q;
  assign dropped_o           = o_drop_q;

endmodule

>>> sim/tb_top.sv
// Testbench for the frame time capture monitor: directed and random items with a predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned WatchLimit = 200000;
  localparam logic [1:0]  CmdUnused  = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  logic [ftcs_pkg::FrameW-1:0] frame_us_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] phase_o;
  logic [ftcs_pkg::TimeW-1:0] remaining_us_o;
  logic [ftcs_pkg::CntW-1:0] count_o;
  logic [ftcs_pkg::TimeW-1:0] captured_total_us_o;
  logic [ftcs_pkg::FrameW-1:0] mean_us_o, p95_us_o, max_us_o;
  logic dropped_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [ftcs_pkg::TimeW-1:0] cfg_data_i = '0;

  frame_time_capture_stats_top dut (.*);

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0]                  phase;
    logic [ftcs_pkg::TimeW-1:0]  remaining;
    logic [ftcs_pkg::CntW-1:0]   count;
    logic [ftcs_pkg::TimeW-1:0]  total;
    logic [ftcs_pkg::FrameW-1:0] mean;
    logic [ftcs_pkg::FrameW-1:0] p95;
    logic [ftcs_pkg::FrameW-1:0] max;
    logic                        dropped;
  } status_t;

  // predictor state
  logic [ftcs_pkg::TimeW-1:0]  warm_budget, capt_budget;
  ftcs_pkg::phase_e            m_phase;
  logic [ftcs_pkg::TimeW-1:0]  m_warm_left, m_capt_left, m_total;
  logic [ftcs_pkg::FrameW-1:0] m_store [ftcs_pkg::MaxSamples];
  int unsigned                 m_count;
  logic                        m_drop;
  logic [ftcs_pkg::FrameW-1:0] m_mean, m_p95, m_max;

  status_t status_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 1'b0;
  int unsigned idle_cycles = 0;

  task automatic clear_model();
    m_phase = ftcs_pkg::PH_IDLE; m_warm_left = '0; m_capt_left = '0; m_total = '0;
    m_count = 0; m_drop = 1'b0; m_mean = '0; m_p95 = '0; m_max = '0;
  endtask

  task automatic summarize();
    logic [ftcs_pkg::FrameW-1:0] srt[$];
    longint unsigned acc;
    int unsigned rank;
    m_phase = ftcs_pkg::PH_DONE;
    m_capt_left = '0;
    if (m_count == 0) return;
    acc = 0;
    for (int i = 0; i < m_count; i++) begin
      srt = {srt, m_store[i]};
      acc += m_store[i];
    end
    srt.sort();
    m_mean = ftcs_pkg::FrameW'(acc / m_count);
    rank = (m_count * 19 + 19) / 20 - 1;
    if (rank >= m_count) rank = m_count - 1;
    m_p95 = srt[rank];
    m_max = srt[m_count-1];
  endtask

  task automatic predict_status(input logic [1:0] cmd,
                                input logic [ftcs_pkg::FrameW-1:0] f);
    status_t s;
    logic [ftcs_pkg::TimeW:0] sum;
    if (cmd == ftcs_pkg::CMD_TICK && f != 0) begin
      if (m_phase == ftcs_pkg::PH_WARM) begin
        if (f >= m_warm_left) begin
          m_warm_left = '0; m_phase = ftcs_pkg::PH_CAPT;
        end else m_warm_left -= f;
      end else if (m_phase == ftcs_pkg::PH_CAPT) begin
        if (m_count < ftcs_pkg::MaxSamples) begin
          m_store[m_count] = f; m_count++;
        end else m_drop = 1'b1;
        sum = m_total + f;
        m_total = sum[ftcs_pkg::TimeW] ? '1 : sum[ftcs_pkg::TimeW-1:0];
        if (f >= m_capt_left) summarize();
        else m_capt_left -= f;
      end
    end else if (cmd == ftcs_pkg::CMD_START) begin
      clear_model();
      if (capt_budget != 0) begin
        m_warm_left = warm_budget; m_capt_left = capt_budget;
        m_phase = (warm_budget != 0) ? ftcs_pkg::PH_WARM : ftcs_pkg::PH_CAPT;
      end
    end else if (cmd == ftcs_pkg::CMD_RESET) clear_model();
    s.phase = m_phase;
    s.remaining = (m_phase == ftcs_pkg::PH_WARM) ? m_warm_left :
                  (m_phase == ftcs_pkg::PH_CAPT) ? m_capt_left : '0;
    s.count = (m_phase == ftcs_pkg::PH_DONE) ? ftcs_pkg::CntW'(m_count) : '0;
    s.total = (m_phase == ftcs_pkg::PH_DONE) ? m_total : '0;
    s.mean = m_mean; s.p95 = m_p95; s.max = m_max; s.dropped = m_drop;
    status_q = {status_q, s};
  endtask

  // leave valid high after acceptance so back to back items keep it asserted
  task automatic send_item(input logic [1:0] cmd, input logic [ftcs_pkg::FrameW-1:0] f);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; cmd_i <= cmd; frame_us_i <= f;
    do @(posedge clk_i); while (!in_ready_o);
    predict_status(cmd, f);
    @(negedge clk_i);
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic write_reg(input ftcs_pkg::reg_e idx, input logic [ftcs_pkg::TimeW-1:0] data);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ftcs_pkg::REG_WARMUP) warm_budget = data; else capt_budget = data;
    @(negedge clk_i);
  endtask

  task automatic drain();
    stop_input();
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic configure(input logic [ftcs_pkg::TimeW-1:0] w,
                           input logic [ftcs_pkg::TimeW-1:0] c);
    drain();
    write_reg(ftcs_pkg::REG_WARMUP, w);
    write_reg(ftcs_pkg::REG_CAPTURE, c);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver
  always @(negedge clk_i)
    out_ready_i <= !hold_recv && !(recv_idle > 0 && $urandom_range(99) < recv_idle);

  always @(posedge clk_i) begin
    status_t act, exp_s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act = '{phase_o, remaining_us_o, count_o, captured_total_us_o,
              mean_us_o, p95_us_o, max_us_o, dropped_o};
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, act);
      end else begin
        exp_s = status_q.pop_front();
        if (act !== exp_s) begin
          errors++;
          $display("%0t mismatch expected %h actual %h", $time, exp_s, act);
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || hold_recv)
      idle_cycles <= 0;
    else if (rst_ni && idle_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic test_directed();
    configure(0, 0);
    send_item(ftcs_pkg::CMD_START, 0);           // zero capture budget stays idle
    send_item(ftcs_pkg::CMD_TICK, 24'd5);        // tick while idle
    send_item(CmdUnused, 24'hFFFFFF);
    configure(32'd10, 32'd30);
    send_item(ftcs_pkg::CMD_START, 0);
    send_item(ftcs_pkg::CMD_TICK, 0);            // zero frame ignored
    send_item(ftcs_pkg::CMD_TICK, 24'd4);
    send_item(ftcs_pkg::CMD_TICK, 24'd100);      // warmup overshoot
    send_item(ftcs_pkg::CMD_TICK, 24'd7);
    send_item(ftcs_pkg::CMD_TICK, 24'd1);
    send_item(ftcs_pkg::CMD_TICK, 24'd50);       // completes
    send_item(ftcs_pkg::CMD_TICK, 24'd3);        // ignored after completion
    send_item(ftcs_pkg::CMD_RESET, 24'd9);
    configure(0, '1);
    send_item(ftcs_pkg::CMD_START, 0);
    send_item(ftcs_pkg::CMD_TICK, 24'hFFFFFF);
    send_item(ftcs_pkg::CMD_TICK, 24'hAAAAAA);
    send_item(ftcs_pkg::CMD_TICK, 24'h555555);
    send_item(ftcs_pkg::CMD_START, 0);           // start clears
    configure('1, 32'd1);
    send_item(ftcs_pkg::CMD_START, 0);
    send_item(ftcs_pkg::CMD_TICK, 24'hFFFFFF);
    send_item(ftcs_pkg::CMD_RESET, 0);
  endtask

  // saturate the total and complete with a few hundred stored samples
  task automatic test_saturation();
    configure(0, '1);
    send_item(ftcs_pkg::CMD_START, 0);
    for (int i = 0; i < 258; i++) send_item(ftcs_pkg::CMD_TICK, 24'hFFFFFF);
  endtask

  task automatic run_captures(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      configure($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 400),
                $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 3000));
      send_item(ftcs_pkg::CMD_START, ftcs_pkg::FrameW'($urandom));
      sent++;
      while (m_phase inside {ftcs_pkg::PH_WARM, ftcs_pkg::PH_CAPT} && sent < n_items) begin
        case ($urandom_range(0, 39))
          0: send_item(ftcs_pkg::CMD_RESET, ftcs_pkg::FrameW'($urandom));
          1: send_item(CmdUnused, ftcs_pkg::FrameW'($urandom));
          2: send_item(ftcs_pkg::CMD_TICK, 0);
          3: send_item(ftcs_pkg::CMD_TICK, ftcs_pkg::FrameW'($urandom));
          default: send_item(ftcs_pkg::CMD_TICK, ftcs_pkg::FrameW'($urandom_range(1, 300)));
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_random();
    send_idle = 29; recv_idle = 73;
    run_captures(100);
    send_idle = 73; recv_idle = 29;
    run_captures(100);
    send_idle = 0; recv_idle = 0;
    run_captures(100);
  endtask

  task automatic test_backpressure();
    configure(0, '1);
    send_item(ftcs_pkg::CMD_START, 0);
    hold_recv = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send_item(ftcs_pkg::CMD_TICK, ftcs_pkg::FrameW'($urandom_range(1, 1000)));
    join
  endtask

  initial begin
    warm_budget = '0; capt_budget = '0;
    clear_model();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    test_saturation();
    drain();
    repeat (100000) begin
      if (status_q.size() == 0) break;
      @(negedge clk_i);
    end
    repeat (20) @(negedge clk_i);
    if (errors == 0 && status_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
